// File: src/tpls_pkg.sv
// ----------------------------------------------------------------------------
// tpls_pkg: shared types and constants of the power limit scaler
// Field widths, pipeline stage counts, register indexes and stage payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package tpls_pkg;

  localparam int SPEED_W    = 16;
  localparam int TORQUE_W   = 24;
  localparam int SCALE_W    = 17;
  localparam int POWER_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COEFF_W    = 32;
  localparam int FACTOR_W   = 31;

  // speed and current magnitudes, Q16.16
  localparam int W_W = SPEED_W + FACTOR_W - 12;
  localparam int I_W = TORQUE_W + FACTOR_W - 24;

  localparam int RAD_W  = 96;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 4;
  localparam int QUO_W  = 16;

  localparam int PWR_STAGES  = 5;
  localparam int PRE_STAGES  = 2;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = QUO_W + 1;
  localparam int NUM_STAGES  = PWR_STAGES + PRE_STAGES + SQRT_STAGES + DIV_STAGES + 1;

  localparam int PRE_BASE  = PWR_STAGES;
  localparam int SQRT_BASE = PRE_BASE + PRE_STAGES;
  localparam int DIV_BASE  = SQRT_BASE + SQRT_STAGES;
  localparam int OUT_STAGE = DIV_BASE + DIV_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROSS   = 3'd0,
    REG_COPPER  = 3'd1,
    REG_IRON    = 3'd2,
    REG_STATIC  = 3'd3,
    REG_SPEED   = 3'd4,
    REG_CURRENT = 3'd5,
    REG_LIMIT   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0]  cross_coeff;
    logic signed [COEFF_W-1:0]  copper_coeff;
    logic signed [COEFF_W-1:0]  iron_coeff;
    logic signed [COEFF_W-1:0]  static_power;
    logic        [FACTOR_W-1:0] speed_scale;
    logic        [FACTOR_W-1:0] current_scale;
  } pwr_cfg_t;

  // what rides along the scale solver
  typedef struct packed {
    logic signed [TORQUE_W-1:0] left_torque;
    logic signed [TORQUE_W-1:0] right_torque;
    logic signed [POWER_W-1:0]  left_power;
    logic signed [POWER_W-1:0]  right_power;
    logic signed [POWER_W-1:0]  total_power;
    logic                       root_ok;
    logic        [31:0]         denom;
  } side_t;

endpackage

`default_nettype wire

// File: src/tpls_if.sv
// ----------------------------------------------------------------------------
// tpls_if: channel interfaces of the power limit scaler
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpls_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tpls_pkg::SPEED_W-1:0]  left_speed;
  logic signed [tpls_pkg::TORQUE_W-1:0] left_torque;
  logic signed [tpls_pkg::SPEED_W-1:0]  right_speed;
  logic signed [tpls_pkg::TORQUE_W-1:0] right_torque;
  modport source (output valid, left_speed, left_torque, right_speed, right_torque,
                  input ready);
  modport sink   (input valid, left_speed, left_torque, right_speed, right_torque,
                  output ready);
endinterface

interface tpls_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tpls_pkg::TORQUE_W-1:0] left_torque_out;
  logic signed [tpls_pkg::TORQUE_W-1:0] right_torque_out;
  logic        [tpls_pkg::SCALE_W-1:0]  scale_factor;
  logic signed [tpls_pkg::POWER_W-1:0]  left_power;
  logic signed [tpls_pkg::POWER_W-1:0]  right_power;
  logic signed [tpls_pkg::POWER_W-1:0]  total_power;
  modport source (output valid, left_torque_out, right_torque_out, scale_factor,
                  left_power, right_power, total_power, input ready);
  modport sink   (input valid, left_torque_out, right_torque_out, scale_factor,
                  left_power, right_power, total_power, output ready);
endinterface

interface tpls_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tpls_pkg::CFG_IDX_W-1:0]     index;
  logic [tpls_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/two_wheel_power_limit_scaler.sv
// ----------------------------------------------------------------------------
// two_wheel_power_limit_scaler: chassis power limit torque scaler
// Estimates both wheel powers and scales the torque pair to the power limit.
// ----------------------------------------------------------------------------
// Pipeline: 5 power stages, 2 setup stages, 48 square root stages,
// 17 quotient stages and 1 output stage, from input to result transfer.
// Throughput: one item per cycle; each stage holds under backpressure.
// Reset: synchronous, clears all stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wheel_power_limit_scaler (
  input  wire logic    clk,
  input  wire logic    rst,
  tpls_in_if.sink      item,
  tpls_out_if.source   result,
  tpls_cfg_if.sink     cfg
);
  import tpls_pkg::*;

  // configuration
  pwr_cfg_t             pcfg;
  logic [FACTOR_W-1:0]  watt_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcfg.cross_coeff   <= 32'sd4229471;
      pcfg.copper_coeff  <= 32'sd52076478;
      pcfg.iron_coeff    <= 32'sd5155;
      pcfg.static_power  <= 32'sd75366;
      pcfg.speed_scale   <= 31'd28110529;
      pcfg.current_scale <= 31'd42689272;
      watt_limit         <= 31'd3276800;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CROSS:   pcfg.cross_coeff   <= cfg.data;
        REG_COPPER:  pcfg.copper_coeff  <= cfg.data;
        REG_IRON:    pcfg.iron_coeff    <= cfg.data;
        REG_STATIC:  pcfg.static_power  <= cfg.data;
        REG_SPEED:   pcfg.speed_scale   <= cfg.data[FACTOR_W-1:0];
        REG_CURRENT: pcfg.current_scale <= cfg.data[FACTOR_W-1:0];
        REG_LIMIT:   watt_limit         <= cfg.data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || result.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign item.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= item.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // power estimate, torques ride alongside
  logic signed [POWER_W-1:0] pl;
  logic signed [POWER_W-1:0] pr;
  logic [PWR_STAGES-1:0][TORQUE_W-1:0] lt_q;
  logic [PWR_STAGES-1:0][TORQUE_W-1:0] rt_q;

  tpls_power u_power_left (
    .clk    (clk),
    .en     (en[PWR_STAGES-1:0]),
    .cfg    (pcfg),
    .speed  (item.left_speed),
    .torque (item.left_torque),
    .power  (pl)
  );

  tpls_power u_power_right (
    .clk    (clk),
    .en     (en[PWR_STAGES-1:0]),
    .cfg    (pcfg),
    .speed  (item.right_speed),
    .torque (item.right_torque),
    .power  (pr)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lt_q[0] <= item.left_torque;
      rt_q[0] <= item.right_torque;
    end
    for (int k = 1; k < PWR_STAGES; k++) begin
      if (en[k]) begin
        lt_q[k] <= lt_q[k-1];
        rt_q[k] <= rt_q[k-1];
      end
    end
  end

  // setup stage 0: sum, denominator and margin below the limit
  logic signed [32:0] s_sum;
  logic signed [33:0] d_full;
  logic signed [33:0] c_full;
  logic signed [33:0] negc_full;
  side_t              side0;
  logic [31:0]        negc0;

  assign s_sum     = $signed({pl[POWER_W-1], pl}) + $signed({pr[POWER_W-1], pr});
  assign d_full    = $signed({s_sum[32], s_sum}) + 34'sd2;
  assign c_full    = $signed({s_sum[32], s_sum}) - $signed({3'b000, watt_limit});
  assign negc_full = -c_full;

  always_ff @(posedge clk) begin
    if (en[PRE_BASE]) begin
      side0.left_torque  <= lt_q[PWR_STAGES-1];
      side0.right_torque <= rt_q[PWR_STAGES-1];
      side0.left_power   <= pl;
      side0.right_power  <= pr;
      if (s_sum[32] != s_sum[31]) begin
        side0.total_power <= s_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        side0.total_power <= s_sum[POWER_W-1:0];
      end
      side0.root_ok <= !d_full[33] && (d_full != '0) && c_full[33];
      side0.denom   <= d_full[31:0];
      negc0         <= negc_full[31:0];
    end
  end

  // setup stage 1: radicand = 2*D*(-C) << 32
  logic [64:0]      x_full;
  side_t            side1;
  logic [RAD_W-1:0] rad1;

  assign x_full = 65'({side0.denom, 1'b0}) * 65'(negc0);

  always_ff @(posedge clk) begin
    if (en[PRE_BASE+1]) begin
      side1 <= side0;
      rad1  <= {x_full[63:0], 32'd0};
    end
  end

  // root, then quotient
  logic [ROOT_W-1:0]  root;
  side_t              side2;
  logic [SCALE_W-1:0] scale;
  side_t              side3;

  tpls_sqrt u_sqrt (
    .clk      (clk),
    .en       (en[SQRT_BASE +: SQRT_STAGES]),
    .rad      (rad1),
    .side     (side1),
    .root     (root),
    .side_out (side2)
  );

  tpls_div u_div (
    .clk      (clk),
    .en       (en[DIV_BASE +: DIV_STAGES]),
    .root     (root),
    .side     (side2),
    .scale    (scale),
    .side_out (side3)
  );

  // output stage: scale the torques
  logic [TORQUE_W-1:0]         labs;
  logic [TORQUE_W-1:0]         rabs;
  logic [TORQUE_W+SCALE_W-1:0] lmul;
  logic [TORQUE_W+SCALE_W-1:0] rmul;
  logic [TORQUE_W-1:0]         lmag;
  logic [TORQUE_W-1:0]         rmag;

  assign labs = side3.left_torque[TORQUE_W-1]  ? (~side3.left_torque + 1'b1)
                                               : side3.left_torque;
  assign rabs = side3.right_torque[TORQUE_W-1] ? (~side3.right_torque + 1'b1)
                                               : side3.right_torque;
  assign lmul = (TORQUE_W+SCALE_W)'(labs) * (TORQUE_W+SCALE_W)'(scale);
  assign rmul = (TORQUE_W+SCALE_W)'(rabs) * (TORQUE_W+SCALE_W)'(scale);
  assign lmag = lmul[TORQUE_W+15:16];
  assign rmag = rmul[TORQUE_W+15:16];

  always_ff @(posedge clk) begin
    if (en[OUT_STAGE]) begin
      result.left_torque_out  <= side3.left_torque[TORQUE_W-1]  ? (~lmag + 1'b1) : lmag;
      result.right_torque_out <= side3.right_torque[TORQUE_W-1] ? (~rmag + 1'b1) : rmag;
      result.scale_factor     <= scale;
      result.left_power       <= side3.left_power;
      result.right_power      <= side3.right_power;
      result.total_power      <= side3.total_power;
    end
  end

  assign result.valid = v[OUT_STAGE];

endmodule

`default_nettype wire

// File: src/tpls_power.sv
// ----------------------------------------------------------------------------
// tpls_power: per-wheel power estimate pipeline
// Five stages: scale to w and I, form products, split coefficient multiply,
// merge partials to Q16.16 terms, sum with offset, saturate, or zero if w or I is 0.
// ----------------------------------------------------------------------------
`default_nettype none

module tpls_power (
  input  wire logic                                 clk,
  input  wire logic [tpls_pkg::PWR_STAGES-1:0]      en,
  input  wire tpls_pkg::pwr_cfg_t                   cfg,
  input  wire logic signed [tpls_pkg::SPEED_W-1:0]  speed,
  input  wire logic signed [tpls_pkg::TORQUE_W-1:0] torque,
  output logic signed [tpls_pkg::POWER_W-1:0]       power
);
  import tpls_pkg::*;

  localparam int PROD_W  = 72;
  localparam int CHUNK_W = PROD_W / 3;
  localparam int PP_W    = CHUNK_W + COEFF_W;
  localparam int FULL_W  = PP_W + 2 * CHUNK_W;

  // term order: cross, copper, iron
  localparam int T_CROSS  = 0;
  localparam int T_COPPER = 1;
  localparam int T_IRON   = 2;

  // stage 0
  logic [SPEED_W-1:0]            sabs;
  logic [TORQUE_W-1:0]           tabs;
  logic [SPEED_W+FACTOR_W-1:0]   wprod;
  logic [TORQUE_W+FACTOR_W-1:0]  iprod;
  logic [W_W-1:0]                wm;
  logic [I_W-1:0]                im;
  logic                          neg0;

  assign sabs  = speed[SPEED_W-1] ? (~speed + 1'b1) : speed;
  assign tabs  = torque[TORQUE_W-1] ? (~torque + 1'b1) : torque;
  assign wprod = (SPEED_W+FACTOR_W)'(sabs) * (SPEED_W+FACTOR_W)'(cfg.speed_scale);
  assign iprod = (TORQUE_W+FACTOR_W)'(tabs) * (TORQUE_W+FACTOR_W)'(cfg.current_scale);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      wm   <= wprod[SPEED_W+FACTOR_W-1:12];
      im   <= iprod[TORQUE_W+FACTOR_W-1:24];
      neg0 <= speed[SPEED_W-1] ^ torque[TORQUE_W-1];
    end
  end

  // stage 1
  logic [2:0][PROD_W-1:0] prod;
  logic                   neg1;
  logic                   zero1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod[T_CROSS]  <= PROD_W'(wm) * PROD_W'(im);
      prod[T_COPPER] <= PROD_W'(im) * PROD_W'(im);
      prod[T_IRON]   <= PROD_W'(wm) * PROD_W'(wm);
      neg1           <= neg0;
      zero1          <= (wm == '0) || (im == '0);
    end
  end

  // stage 2: coefficient magnitude times product, in three chunks
  logic [2:0][COEFF_W-1:0]       kabs;
  logic [2:0]                    kneg;
  logic [2:0][2:0][PP_W-1:0]     pp;
  logic [2:0]                    neg2;
  logic                          zero2;

  always_comb begin
    kneg[T_CROSS]  = cfg.cross_coeff[COEFF_W-1];
    kneg[T_COPPER] = cfg.copper_coeff[COEFF_W-1];
    kneg[T_IRON]   = cfg.iron_coeff[COEFF_W-1];
    kabs[T_CROSS]  = kneg[T_CROSS]  ? (~cfg.cross_coeff + 1'b1)  : cfg.cross_coeff;
    kabs[T_COPPER] = kneg[T_COPPER] ? (~cfg.copper_coeff + 1'b1) : cfg.copper_coeff;
    kabs[T_IRON]   = kneg[T_IRON]   ? (~cfg.iron_coeff + 1'b1)   : cfg.iron_coeff;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int t = 0; t < 3; t++) begin
        for (int j = 0; j < 3; j++) begin
          pp[t][j] <= PP_W'(prod[t][j*CHUNK_W +: CHUNK_W]) * PP_W'(kabs[t]);
        end
      end
      neg2[T_CROSS]  <= neg1 ^ kneg[T_CROSS];
      neg2[T_COPPER] <= kneg[T_COPPER];
      neg2[T_IRON]   <= kneg[T_IRON];
      zero2          <= zero1;
    end
  end

  // stage 3: merge partials, drop 44 fraction bits, apply sign
  logic [2:0][FULL_W-1:0] full;
  logic [2:0][63:0]       term;
  logic                   zero3;

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      full[t] = FULL_W'(pp[t][0])
              + (FULL_W'(pp[t][1]) << CHUNK_W)
              + (FULL_W'(pp[t][2]) << (2 * CHUNK_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int t = 0; t < 3; t++) begin
        term[t] <= neg2[t] ? (64'd0 - 64'(full[t][FULL_W-1:44]))
                           : 64'(full[t][FULL_W-1:44]);
      end
      zero3 <= zero2;
    end
  end

  // stage 4
  logic signed [63:0] sum;

  assign sum = $signed(term[T_CROSS] + term[T_COPPER] + term[T_IRON]
                       + 64'($signed(cfg.static_power)));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (zero3) begin
        power <= '0;
      end else if (sum > 64'sd2147483647) begin
        power <= 32'sh7fffffff;
      end else if (sum < -64'sd2147483648) begin
        power <= 32'sh80000000;
      end else begin
        power <= sum[POWER_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/tpls_sqrt.sv
// ----------------------------------------------------------------------------
// tpls_sqrt: pipelined integer square root
// One result bit per stage, restoring method over the full radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module tpls_sqrt (
  input  wire logic                               clk,
  input  wire logic [tpls_pkg::SQRT_STAGES-1:0]   en,
  input  wire logic [tpls_pkg::RAD_W-1:0]         rad,
  input  wire tpls_pkg::side_t                    side,
  output logic [tpls_pkg::ROOT_W-1:0]             root,
  output tpls_pkg::side_t                         side_out
);
  import tpls_pkg::*;

  logic [SQRT_STAGES-1:0][RAD_W-1:0]  rad_q;
  logic [SQRT_STAGES-1:0][REM_W-1:0]  rem_q;
  logic [SQRT_STAGES-1:0][ROOT_W-1:0] root_q;
  side_t                              side_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    side_t             side_i;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side;
    end else begin : g_next
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_i, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rad_q[k]  <= {rad_i[RAD_W-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_i[ROOT_W-2:0], ge};
        side_q[k] <= side_i;
      end
    end
  end

  assign root     = root_q[SQRT_STAGES-1];
  assign side_out = side_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: src/tpls_div.sv
// ----------------------------------------------------------------------------
// tpls_div: pipelined scale quotient
// Clamp check against one, then one quotient bit per stage of root / denom.
// ----------------------------------------------------------------------------
`default_nettype none

module tpls_div (
  input  wire logic                              clk,
  input  wire logic [tpls_pkg::DIV_STAGES-1:0]   en,
  input  wire logic [tpls_pkg::ROOT_W-1:0]       root,
  input  wire tpls_pkg::side_t                   side,
  output logic [tpls_pkg::SCALE_W-1:0]           scale,
  output tpls_pkg::side_t                        side_out
);
  import tpls_pkg::*;

  logic [DIV_STAGES-1:0][ROOT_W-1:0] rem_q;
  logic [DIV_STAGES-1:0][QUO_W-1:0]  quo_q;
  logic [DIV_STAGES-1:0]             clamp_q;
  side_t                             side_q [DIV_STAGES];

  // quotient at or above one clamps
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_q[0]   <= root;
      quo_q[0]   <= '0;
      clamp_q[0] <= root >= {side.denom, 16'd0};
      side_q[0]  <= side;
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    logic [ROOT_W-1:0] dsh;
    logic              ge;

    assign dsh = {16'd0, side_q[k-1].denom} << (DIV_STAGES - 1 - k);
    assign ge  = rem_q[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k]   <= ge ? (rem_q[k-1] - dsh) : rem_q[k-1];
        quo_q[k]   <= quo_q[k-1] | (QUO_W'(ge) << (DIV_STAGES - 1 - k));
        clamp_q[k] <= clamp_q[k-1];
        side_q[k]  <= side_q[k-1];
      end
    end
  end

  always_comb begin
    if (!side_q[DIV_STAGES-1].root_ok) begin
      scale = '0;
    end else if (clamp_q[DIV_STAGES-1]) begin
      scale = SCALE_W'(1) << QUO_W;
    end else begin
      scale = SCALE_W'(quo_q[DIV_STAGES-1]);
    end
  end

  assign side_out = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: tb/two_wheel_power_limit_scaler_checker.sv
// ----------------------------------------------------------------------------
// two_wheel_power_limit_scaler_checker: result predictor and scoreboard
// Watches the input, result and configuration channels. Keeps its own copy of
// the registers, predicts each result at input transfer time and compares
// every result transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wheel_power_limit_scaler_checker (
  input  wire logic clk,
  input  wire logic rst,
  tpls_in_if        item,
  tpls_out_if       result,
  tpls_cfg_if       cfg,
  output int        fails,
  output int        pending
);
  import tpls_pkg::*;

  typedef struct {
    logic signed [TORQUE_W-1:0] left_torque_out;
    logic signed [TORQUE_W-1:0] right_torque_out;
    logic        [SCALE_W-1:0]  scale_factor;
    logic signed [POWER_W-1:0]  left_power;
    logic signed [POWER_W-1:0]  right_power;
    logic signed [POWER_W-1:0]  total_power;
  } scaled_pair_t;

  scaled_pair_t scaled_q[$];

  logic signed [COEFF_W-1:0]  cross_k, copper_k, iron_k, static_w;
  logic        [FACTOR_W-1:0] speed_k, current_k, limit_w;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // k (Q4.28) times two Q16.16 magnitudes, back to signed Q16.16
  function automatic longint loss_term(logic signed [31:0] k, logic [63:0] a,
                                       logic [63:0] b, bit neg);
    longint       kk;
    logic [127:0] p;
    logic [63:0]  mag;
    kk  = k;
    p   = {64'd0, a} * {64'd0, b};
    p   = p * {64'd0, 64'(kk < 0 ? -kk : kk)};
    mag = p[107:44];
    if (kk < 0) neg = !neg;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint wheel_watts(logic signed [SPEED_W-1:0] spd,
                                         logic signed [TORQUE_W-1:0] trq);
    longint      s, t, acc;
    logic [63:0] wm, im;
    s  = spd;
    t  = trq;
    wm = (64'(s < 0 ? -s : s) * 64'(speed_k)) >> 12;
    im = (64'(t < 0 ? -t : t) * 64'(current_k)) >> 24;
    if (wm == 0 || im == 0) return 0;
    acc = loss_term(cross_k, wm, im, (s < 0) != (t < 0))
        + loss_term(copper_k, im, im, 1'b0)
        + loss_term(iron_k, wm, wm, 1'b0)
        + longint'(static_w);
    return clamp32(acc);
  endfunction

  // largest s in [0,65536] with (s*D)^2 <= 2*D*(-C)*2^32, or 0 unless D > 0 and C < 0
  function automatic logic [SCALE_W-1:0] limit_scale(longint sum);
    longint       d, c, lo, hi, mid;
    logic [63:0]  x;
    logic [127:0] rhs, q;
    d = sum + 2;
    c = sum - longint'(limit_w);
    if (!(d > 0 && c < 0)) return '0;
    x   = 64'd2 * 64'(d) * 64'(-c);
    rhs = {64'd0, x} << 32;
    lo  = 0;
    hi  = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      q   = {64'd0, 64'(mid)} * {64'd0, 64'(d)};
      if (q * q <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return SCALE_W'(lo);
  endfunction

  function automatic logic signed [TORQUE_W-1:0] trim_torque(
      logic signed [TORQUE_W-1:0] trq, logic [SCALE_W-1:0] s16);
    longint      t;
    logic [63:0] mag;
    t   = trq;
    mag = (64'(t < 0 ? -t : t) * 64'(s16)) >> 16;
    return TORQUE_W'(t < 0 ? -longint'(mag) : longint'(mag));
  endfunction

  task automatic report(string field, longint want, longint got);
    if (want != got) begin
      fails++;
      $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    scaled_pair_t exp_pair;
    longint       pl, pr;
    if (rst) begin
      cross_k   <= 32'sd4229471;
      copper_k  <= 32'sd52076478;
      iron_k    <= 32'sd5155;
      static_w  <= 32'sd75366;
      speed_k   <= 31'd28110529;
      current_k <= 31'd42689272;
      limit_w   <= 31'd3276800;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_CROSS:   cross_k   <= cfg.data;
          REG_COPPER:  copper_k  <= cfg.data;
          REG_IRON:    iron_k    <= cfg.data;
          REG_STATIC:  static_w  <= cfg.data;
          REG_SPEED:   speed_k   <= cfg.data[FACTOR_W-1:0];
          REG_CURRENT: current_k <= cfg.data[FACTOR_W-1:0];
          REG_LIMIT:   limit_w   <= cfg.data[FACTOR_W-1:0];
          default: ;  // drop writes to unused indexes
        endcase
      end
      if (item.valid && item.ready) begin
        pl = wheel_watts(item.left_speed, item.left_torque);
        pr = wheel_watts(item.right_speed, item.right_torque);
        exp_pair.scale_factor     = limit_scale(pl + pr);
        exp_pair.left_torque_out  = trim_torque(item.left_torque, exp_pair.scale_factor);
        exp_pair.right_torque_out = trim_torque(item.right_torque, exp_pair.scale_factor);
        exp_pair.left_power       = POWER_W'(pl);
        exp_pair.right_power      = POWER_W'(pr);
        exp_pair.total_power      = POWER_W'(clamp32(pl + pr));
        scaled_q.push_back(exp_pair);
      end
      if (result.valid && result.ready) begin
        if (scaled_q.size() == 0) begin
          fails++;
          $display("%0t unexpected result: expected none, actual scale %0d", $time,
                   result.scale_factor);
        end else begin
          exp_pair = scaled_q.pop_front();
          report("left_torque_out", exp_pair.left_torque_out, result.left_torque_out);
          report("right_torque_out", exp_pair.right_torque_out, result.right_torque_out);
          report("scale_factor", exp_pair.scale_factor, result.scale_factor);
          report("left_power", exp_pair.left_power, result.left_power);
          report("right_power", exp_pair.right_power, result.right_power);
          report("total_power", exp_pair.total_power, result.total_power);
        end
      end
      pending = scaled_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/two_wheel_power_limit_scaler_tb.sv
// ----------------------------------------------------------------------------
// two_wheel_power_limit_scaler_tb: top of the power limit scaler testbench
// Resets the block, walks it through several register settings and drives
// directed and random wheel pairs with random gaps and stalls on both sides.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wheel_power_limit_scaler_tb;
  import tpls_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 100;
  localparam int CHOKE_CYCLES = 250;
  localparam longint CYCLE_LIMIT = 400000;

  logic   clk;
  logic   rst;
  int     fails;
  int     pending;
  bit     idle_on;
  int     choke_req;
  longint cycles;

  tpls_in_if  item();
  tpls_out_if result();
  tpls_cfg_if cfg();

  two_wheel_power_limit_scaler dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  two_wheel_power_limit_scaler_checker scoreboard (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .result  (result),
    .cfg     (cfg),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("two_wheel_power_limit_scaler: mismatch");
        $finish;
      end
    end
  end

  // result side: random stalls, and a long hold-off on each request
  initial begin
    int n;
    int choke_done;
    choke_done   = 0;
    result.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (choke_req != choke_done) begin
        choke_done = choke_req;
        result.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
      end
      n = idle_on ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        result.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!(result.valid && result.ready));
      @(negedge clk);
    end
  end

  task automatic send_pair(logic signed [SPEED_W-1:0] ls, logic signed [TORQUE_W-1:0] lt,
                           logic signed [SPEED_W-1:0] rs, logic signed [TORQUE_W-1:0] rt);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid        <= 1'b1;
    item.left_speed   <= ls;
    item.left_torque  <= lt;
    item.right_speed  <= rs;
    item.right_torque <= rt;
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // hold the sender until every expected result is back
  task automatic drain();
    @(negedge clk);
    item.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                           logic [31:0] k3, logic [31:0] k4, logic [31:0] k5,
                           logic [31:0] k6);
    drain();
    write_reg(REG_CROSS, k0);
    write_reg(REG_COPPER, k1);
    write_reg(REG_IRON, k2);
    write_reg(REG_STATIC, k3);
    write_reg(REG_SPEED, k4);
    write_reg(REG_CURRENT, k5);
    write_reg(REG_LIMIT, k6);
  endtask

  function automatic int span(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic logic [31:0] pick_edge(int w);
    case ($urandom_range(0, 3))
      0: return 32'(-(64'sd1 <<< (w - 1)));
      1: return 32'((64'sd1 <<< (w - 1)) - 1);
      2: return 32'd0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic random_pairs(int count, bit with_choke);
    logic [SPEED_W-1:0]  ls, rs;
    logic [TORQUE_W-1:0] lt, rt;
    for (int n = 0; n < count; n++) begin
      idle_on = (n % 120) >= 30;
      if (with_choke && n == 8) choke_req++;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          ls = 16'(span(700));   lt = 24'(span(50000));
          rs = 16'(span(700));   rt = 24'(span(50000));
        end
        5: begin
          ls = 16'(span(6000));  lt = 24'(span(500000));
          rs = 16'(span(6000));  rt = 24'(span(500000));
        end
        6: begin
          ls = $urandom_range(0, 1) ? 16'd0 : 16'(span(700));
          lt = 24'(span(50000));
          rs = 16'(span(700));
          rt = $urandom_range(0, 1) ? 24'd0 : 24'(span(50000));
        end
        7: begin
          ls = 16'(pick_edge(SPEED_W));  lt = 24'(pick_edge(TORQUE_W));
          rs = 16'(pick_edge(SPEED_W));  rt = 24'(pick_edge(TORQUE_W));
        end
        default: begin
          ls = 16'($urandom);  lt = 24'($urandom);
          rs = 16'($urandom);  rt = 24'($urandom);
        end
      endcase
      send_pair(ls, lt, rs, rt);
    end
  endtask

  initial begin
    rst          = 1'b1;
    idle_on      = 1'b0;
    item.valid   = 1'b0;
    item.left_speed   = '0;
    item.left_torque  = '0;
    item.right_speed  = '0;
    item.right_torque = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: field extremes, zero speed or torque, tiny and large loads
    send_pair(16'(0), 24'(0), 16'(0), 24'(0));
    send_pair(16'(32767), 24'(8388607), 16'(-32768), 24'(-8388608));
    send_pair(16'(-32768), 24'(-8388608), 16'(32767), 24'(8388607));
    send_pair(16'(0), 24'(8388607), 16'(100), 24'(0));
    send_pair(16'(1), 24'(1), 16'(1), 24'(1));
    send_pair(16'(-1), 24'(-1), 16'(-1), 24'(-1));
    send_pair(16'(300), 24'(20000), 16'(300), 24'(20000));
    send_pair(16'(-300), 24'(-20000), 16'(300), 24'(-20000));
    send_pair(16'(600), 24'(40000), 16'(-600), 24'(40000));
    send_pair(16'(100), 24'(65536), 16'(100), 24'(65536));
    send_pair(16'(5000), 24'(300000), 16'(5000), 24'(300000));
    send_pair(16'(2000), 24'(100000), 16'(0), 24'(0));
    send_pair(16'(12), 24'(3000), 16'(-12), 24'(-3000));
    send_pair(16'(-32768), 24'(1), 16'(1), 24'(-8388608));
    random_pairs(150, 1'b1);

    load_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    random_pairs(148, 1'b0);

    load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'd0, 32'd0, 32'd0);
    random_pairs(148, 1'b0);

    // negative losses can drive the denominator to zero or below
    load_regs(-32'sd4229471, -32'sd52076478, -32'sd5155, -32'sd75366,
              32'd28110529, 32'd42689272, 32'd3276800);
    random_pairs(148, 1'b1);

    load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    write_reg(REG_UNUSED, $urandom);
    random_pairs(148, 1'b0);

    load_regs(32'd4229471, 32'd52076478, 32'd5155, 32'd75366,
              32'd28110529, 32'd42689272, 32'h7fff_ffff);
    random_pairs(148, 1'b0);

    load_regs(span(8000000), $urandom_range(0, 100000000), span(20000),
              span(400000), $urandom_range(0, 60000000),
              $urandom_range(0, 90000000), $urandom_range(0, 20000000));
    random_pairs(148, 1'b0);

    drain();
    if (fails == 0) begin
      $display("two_wheel_power_limit_scaler: match");
    end else begin
      $display("two_wheel_power_limit_scaler: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
